// ===== src/direct_dft_engine_defines.svh =====
// Assertion helpers for the DFT engine; expects clk and rst_n in scope.
`ifndef DIRECT_DFT_ENGINE_DEFINES_SVH
`define DIRECT_DFT_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define DDE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dde_pkg.sv =====
package dde_pkg;

  localparam int MAX_POINTS    = 64;
  localparam int PTR_BITS      = $clog2(MAX_POINTS);
  localparam int LOG2_BITS     = 3;
  localparam logic [LOG2_BITS-1:0] LOG2_MAX = LOG2_BITS'(PTR_BITS);
  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = SAMPLE_BITS - 1;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS - FRAC_BITS;
  localparam int ACC_BITS      = 24;
  localparam int OUT_BITS      = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SIZE_LOG2 = 2'd0,
    CFG_INVERSE   = 2'd1
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  typedef struct packed {
    smp_t re;
    smp_t im;
  } cplx_t;

  // one MAC issue slot from the sequencer
  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic                last_bin;
    logic [PTR_BITS-1:0] phase;
  } issue_t;

  // sin(pi*j/32) in Q15, rounded half up, 1.0 saturated
  function automatic smp_t quarter_sin(input logic [4:0] j);
    smp_t v;
    case (j)
      5'd0:    v = 16'sd0;
      5'd1:    v = 16'sd3212;
      5'd2:    v = 16'sd6393;
      5'd3:    v = 16'sd9512;
      5'd4:    v = 16'sd12540;
      5'd5:    v = 16'sd15447;
      5'd6:    v = 16'sd18205;
      5'd7:    v = 16'sd20788;
      5'd8:    v = 16'sd23170;
      5'd9:    v = 16'sd25330;
      5'd10:   v = 16'sd27246;
      5'd11:   v = 16'sd28899;
      5'd12:   v = 16'sd30274;
      5'd13:   v = 16'sd31357;
      5'd14:   v = 16'sd32138;
      5'd15:   v = 16'sd32610;
      5'd16:   v = 16'sd32767;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // full-circle twiddle: re = cos, im = sin of 2*pi*idx/MAX_POINTS
  function automatic cplx_t twiddle(input logic [PTR_BITS-1:0] idx);
    logic [3:0] m;
    smp_t       c;
    smp_t       s;
    cplx_t      w;
    m = idx[3:0];
    c = quarter_sin(5'd16 - {1'b0, m});
    s = quarter_sin({1'b0, m});
    case (idx[PTR_BITS-1 -: 2])
      2'd0:    begin w.re = c;  w.im = s;  end
      2'd1:    begin w.re = -s; w.im = c;  end
      2'd2:    begin w.re = -c; w.im = -s; end
      default: begin w.re = s;  w.im = -c; end
    endcase
    return w;
  endfunction

endpackage

// ===== src/dde_sample_store.sv =====
module dde_sample_store
  import dde_pkg::*;
(
  input  logic                clk,
  input  logic                wr_en,
  input  logic [PTR_BITS-1:0] wr_addr,
  input  cplx_t               wr_data,
  input  logic [PTR_BITS-1:0] rd_addr,
  output cplx_t               rd_data
);

  cplx_t mem [MAX_POINTS];
  cplx_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/dde_seq.sv =====
module dde_seq
  import dde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [LOG2_BITS-1:0] lg,
  input  logic                 done_bin,
  output logic                 busy,
  output logic                 wr_en,
  output logic [PTR_BITS-1:0]  wr_addr,
  output logic [PTR_BITS-1:0]  rd_addr,
  output issue_t               issue
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t              state_r;
  logic [PTR_BITS-1:0] load_cnt_r;
  logic [PTR_BITS-1:0] t_r;
  logic [PTR_BITS-1:0] k_r;
  logic [PTR_BITS-1:0] phase_r;
  logic [PTR_BITS-1:0] step_r;

  logic [PTR_BITS:0]   n_pts;
  logic [PTR_BITS:0]   n_m1_w;
  logic [PTR_BITS:0]   inc_w;
  logic [PTR_BITS-1:0] n_m1;
  logic [PTR_BITS-1:0] inc;
  logic [PTR_BITS:0]   cnt_p1;
  logic                accept;
  logic                blk_done;

  assign n_pts    = (PTR_BITS+1)'(1) << lg;
  assign n_m1_w   = n_pts - 1'b1;
  assign n_m1     = n_m1_w[PTR_BITS-1:0];
  // phase step between bins is MAX_POINTS/n, wraps to zero when n is one
  assign inc_w    = (PTR_BITS+1)'(MAX_POINTS) >> lg;
  assign inc      = inc_w[PTR_BITS-1:0];
  assign cnt_p1   = {1'b0, load_cnt_r} + 1'b1;
  assign accept   = start && (state_r == ST_IDLE);
  assign blk_done = (cnt_p1 >= n_pts);

  assign busy    = (state_r != ST_IDLE);
  assign wr_en   = accept;
  assign wr_addr = load_cnt_r;
  assign rd_addr = t_r;

  always_comb begin
    issue.vld      = (state_r == ST_RUN);
    issue.first    = (t_r == '0);
    issue.last     = (t_r == n_m1);
    issue.last_bin = (t_r == n_m1) && (k_r == n_m1);
    issue.phase    = phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      t_r        <= '0;
      k_r        <= '0;
      phase_r    <= '0;
      step_r     <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (blk_done) begin
              load_cnt_r <= '0;
              t_r        <= '0;
              k_r        <= '0;
              phase_r    <= '0;
              step_r     <= '0;
              state_r    <= ST_RUN;
            end else begin
              load_cnt_r <= cnt_p1[PTR_BITS-1:0];
            end
          end
        end
        ST_RUN: begin
          if (issue.last) begin
            t_r     <= '0;
            phase_r <= '0;
            k_r     <= k_r + 1'b1;
            step_r  <= step_r + inc;
            if (issue.last_bin) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            t_r     <= t_r + 1'b1;
            phase_r <= phase_r + step_r;
          end
        end
        ST_DRAIN: begin
          if (done_bin) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/dde_cmac.sv =====
module dde_cmac
  import dde_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  issue_t                     issue,
  input  cplx_t                      smp,
  input  logic                       inv,
  input  logic [LOG2_BITS-1:0]       lg,
  output logic                       out_vld,
  output logic                       out_last,
  output logic signed [OUT_BITS-1:0] out_re,
  output logic signed [OUT_BITS-1:0] out_im
);

  issue_t ctl1_r;
  issue_t ctl2_r;
  smp_t   cos1_r;
  smp_t   sin1_r;
  prod_t  p_rc_r;
  prod_t  p_is_r;
  prod_t  p_rs_r;
  prod_t  p_ic_r;
  acc_t   acc_re_r;
  acc_t   acc_im_r;
  logic   out_vld_r;
  logic   out_last_r;
  acc_t   out_re_r;
  acc_t   out_im_r;

  cplx_t  tw;
  smp_t   sin_eff;
  logic signed [2*SAMPLE_BITS-1:0] m_rc;
  logic signed [2*SAMPLE_BITS-1:0] m_is;
  logic signed [2*SAMPLE_BITS-1:0] m_rs;
  logic signed [2*SAMPLE_BITS-1:0] m_ic;
  acc_t   base_re;
  acc_t   base_im;
  acc_t   sum_re;
  acc_t   sum_im;

  // forward uses cos - j sin, inverse the conjugate
  assign tw      = twiddle(issue.phase);
  assign sin_eff = inv ? tw.im : -tw.im;

  assign m_rc = smp.re * cos1_r;
  assign m_is = smp.im * sin1_r;
  assign m_rs = smp.re * sin1_r;
  assign m_ic = smp.im * cos1_r;

  // |sum| stays below 2^22 for 64 points, so the accumulator never wraps
  assign base_re = ctl2_r.first ? '0 : acc_re_r;
  assign base_im = ctl2_r.first ? '0 : acc_im_r;
  assign sum_re  = base_re + acc_t'(p_rc_r) - acc_t'(p_is_r);
  assign sum_im  = base_im + acc_t'(p_rs_r) + acc_t'(p_ic_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r     <= '0;
      ctl2_r     <= '0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      ctl1_r     <= issue;
      ctl2_r     <= ctl1_r;
      out_vld_r  <= ctl2_r.vld && ctl2_r.last;
      out_last_r <= ctl2_r.vld && ctl2_r.last_bin;
    end
  end

  always_ff @(posedge clk) begin
    cos1_r <= tw.re;
    sin1_r <= sin_eff;
    // floor shift of each product back to Q15
    p_rc_r <= m_rc[2*SAMPLE_BITS-1:FRAC_BITS];
    p_is_r <= m_is[2*SAMPLE_BITS-1:FRAC_BITS];
    p_rs_r <= m_rs[2*SAMPLE_BITS-1:FRAC_BITS];
    p_ic_r <= m_ic[2*SAMPLE_BITS-1:FRAC_BITS];
    if (ctl2_r.vld) begin
      acc_re_r <= sum_re;
      acc_im_r <= sum_im;
    end
    out_re_r <= inv ? (sum_re >>> lg) : sum_re;
    out_im_r <= inv ? (sum_im >>> lg) : sum_im;
  end

  assign out_vld  = out_vld_r;
  assign out_last = out_last_r;
  assign out_re   = OUT_BITS'(out_re_r);
  assign out_im   = OUT_BITS'(out_im_r);

endmodule

// ===== src/direct_dft_engine.sv =====
// Direct DFT engine. Samples (Q1.15 complex) are loaded one per transaction:
// start is taken whenever busy is low, and a sample that does not complete a
// block leaves busy low. The sample that completes a block of n = 2^size_log2
// points (size_log2 above 6 acts as 6) raises busy and starts the transform.
// All n bins then come out in order k = 0 .. n-1, each on out_valid for
// exactly one cycle with no way to hold it off; out_last_bin marks bin n-1.
// Busy falls the cycle after the last bin. The transform time is set by the
// single complex multiply-accumulate unit, which takes one stored sample and
// one twiddle per cycle. Configuration writes are always accepted (cfg_ready
// is tied high) and must only be issued while busy is low; inverse_mode
// selects conjugate twiddles and an arithmetic shift right by size_log2 per
// bin.
`include "direct_dft_engine_defines.svh"

module direct_dft_engine
  import dde_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // sample channel
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_real,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_imag,
  // bin channel
  output logic                       out_valid,
  output logic signed [OUT_BITS-1:0] out_bin_real,
  output logic signed [OUT_BITS-1:0] out_bin_imag,
  output logic                       out_last_bin,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  // configuration registers
  logic [LOG2_BITS-1:0] size_log2_r;
  logic                 inverse_mode_r;
  logic [LOG2_BITS-1:0] lg;

  // sequencer <-> store / MAC
  logic                 wr_en;
  logic [PTR_BITS-1:0]  wr_addr;
  logic [PTR_BITS-1:0]  rd_addr;
  cplx_t                wr_data;
  cplx_t                rd_data;
  issue_t               issue;
  logic                 done_bin;

  assign cfg_ready = 1'b1;

  // unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r    <= LOG2_MAX;
      inverse_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SIZE_LOG2: size_log2_r    <= cfg_data;
        CFG_INVERSE:   inverse_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // oversized lengths clamp to the largest supported block
  assign lg = (size_log2_r > LOG2_MAX) ? LOG2_MAX : size_log2_r;

  assign wr_data.re = in_sample_real;
  assign wr_data.im = in_sample_imag;
  assign done_bin   = out_valid && out_last_bin;

  // load counter, bin/time counters and twiddle phase
  dde_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .lg       (lg),
    .done_bin (done_bin),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .issue    (issue)
  );

  // sample buffer, one write and one registered read per cycle
  dde_sample_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared complex MAC: twiddle, products, accumulate and scale
  dde_cmac u_cmac (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .smp      (rd_data),
    .inv      (inverse_mode_r),
    .lg       (lg),
    .out_vld  (out_valid),
    .out_last (out_last_bin),
    .out_re   (out_bin_real),
    .out_im   (out_bin_imag)
  );

  // a bin only ever comes out during a transform
  `DDE_ASSERT_IMPLY(a_bin_while_busy, out_valid, busy, "bin strobe while idle")
  // the final bin ends the transaction and frees the engine
  `DDE_ASSERT_NEXT(a_idle_after_last, out_valid && out_last_bin, !busy, "busy after final bin")
  // last flag never stands without its strobe
  `DDE_ASSERT_IMPLY(a_last_with_strobe, out_last_bin, out_valid, "last bin without strobe")

endmodule
